// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by the alu top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/c8alu_pkg.sv
// types, operation codes and flag positions of the 8-bit alu
package c8alu_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned OP_W   = 4;

    // status byte bit positions
    localparam int unsigned FLAG_N = 7;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_C = 0;

    typedef enum logic [OP_W-1:0] {
        OP_ADC = 4'd0,
        OP_SBC = 4'd1,
        OP_AND = 4'd2,
        OP_ORA = 4'd3,
        OP_EOR = 4'd4,
        OP_BIT = 4'd5,
        OP_CMP = 4'd6,
        OP_CPX = 4'd7,
        OP_CPY = 4'd8,
        OP_ASL = 4'd9,
        OP_LSR = 4'd10,
        OP_ROL = 4'd11,
        OP_ROR = 4'd12
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]   req_type;
        logic [DATA_W-1:0] operand;
        logic              shift_accumulator;
        logic [DATA_W-1:0] acc_in;
        logic [DATA_W-1:0] index_x;
        logic [DATA_W-1:0] index_y;
        logic [DATA_W-1:0] status_in;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] acc_out;
        logic [DATA_W-1:0] mem_out;
        logic [DATA_W-1:0] status_out;
    } t_res;

endpackage

// File: hw/rtl/c8alu_core.sv
// combinational datapath: shared adder, logic unit, shifter and flag update
module c8alu_core (
    input  c8alu_pkg::t_req i_req,
    output c8alu_pkg::t_res o_res
);
    import c8alu_pkg::*;

    t_op               op;
    logic [DATA_W-1:0] add_a;
    logic [DATA_W-1:0] add_b;
    logic              add_cin;
    logic [DATA_W:0]   add_sum;
    logic [DATA_W-1:0] add_r;
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] shf_r;
    logic              shf_c;
    logic              is_shift;
    logic [DATA_W-1:0] logic_r;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] st;
    logic              cin;

    assign op  = t_op'(i_req.req_type);
    assign cin = i_req.status_in[FLAG_C];
    assign src = i_req.shift_accumulator ? i_req.acc_in : i_req.operand;

    // one adder serves add, subtract and the three compares
    always_comb begin
        add_a   = i_req.acc_in;
        add_b   = i_req.operand;
        add_cin = cin;
        case (op)
            OP_SBC: begin
                add_b = ~i_req.operand;
            end
            OP_CMP: begin
                add_b   = ~i_req.operand;
                add_cin = 1'b1;
            end
            OP_CPX: begin
                add_a   = i_req.index_x;
                add_b   = ~i_req.operand;
                add_cin = 1'b1;
            end
            OP_CPY: begin
                add_a   = i_req.index_y;
                add_b   = ~i_req.operand;
                add_cin = 1'b1;
            end
            default: begin
                add_cin = cin;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};
    assign add_r   = add_sum[DATA_W-1:0];

    // shifter
    always_comb begin
        is_shift = 1'b1;
        shf_r    = src;
        shf_c    = src[DATA_W-1];
        case (op)
            OP_ASL: begin
                shf_r = {src[DATA_W-2:0], 1'b0};
            end
            OP_ROL: begin
                shf_r = {src[DATA_W-2:0], cin};
            end
            OP_LSR: begin
                shf_r = {1'b0, src[DATA_W-1:1]};
                shf_c = src[0];
            end
            OP_ROR: begin
                shf_r = {cin, src[DATA_W-1:1]};
                shf_c = src[0];
            end
            default: begin
                is_shift = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (op)
            OP_AND:  logic_r = i_req.acc_in & i_req.operand;
            OP_ORA:  logic_r = i_req.acc_in | i_req.operand;
            default: logic_r = i_req.acc_in ^ i_req.operand;
        endcase
    end

    // result select and flag update
    always_comb begin
        acc = i_req.acc_in;
        st  = i_req.status_in;
        case (op)
            OP_ADC, OP_SBC: begin
                acc         = add_r;
                st[FLAG_N]  = add_r[DATA_W-1];
                st[FLAG_Z]  = (add_r == '0);
                st[FLAG_C]  = add_sum[DATA_W];
                st[FLAG_V]  = ~(i_req.acc_in[DATA_W-1] ^ add_b[DATA_W-1])
                            & (i_req.acc_in[DATA_W-1] ^ add_r[DATA_W-1]);
            end
            OP_AND, OP_ORA, OP_EOR: begin
                acc        = logic_r;
                st[FLAG_N] = logic_r[DATA_W-1];
                st[FLAG_Z] = (logic_r == '0);
            end
            OP_BIT: begin
                st[FLAG_N] = i_req.operand[DATA_W-1];
                st[FLAG_V] = i_req.operand[DATA_W-2];
                st[FLAG_Z] = ((i_req.acc_in & i_req.operand) == '0);
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                st[FLAG_N] = add_r[DATA_W-1];
                st[FLAG_Z] = (add_r == '0);
                st[FLAG_C] = add_sum[DATA_W];
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                st[FLAG_N] = shf_r[DATA_W-1];
                st[FLAG_Z] = (shf_r == '0);
                st[FLAG_C] = shf_c;
            end
            default: begin
                acc = i_req.acc_in;
            end
        endcase
    end

    assign o_res.acc_out    = (is_shift && i_req.shift_accumulator) ? shf_r : acc;
    assign o_res.mem_out    = (is_shift && !i_req.shift_accumulator) ? shf_r : i_req.operand;
    assign o_res.status_out = st;

endmodule

// File: hw/rtl/cpu8_alu_with_flags.sv
// top level of the 8-bit alu: input register, datapath and result register
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  request  | i_valid / o_ready  | i_req_type i_operand i_shift_accumulator
//           |                    | i_acc_in i_index_x i_index_y i_status_in
//  result   | o_valid / i_ready  | o_acc_out o_mem_out o_status_out
//
// one item per cycle sustained while the result side takes results; an accepted item waits in
// the input register and moves on to the result register, which drives o_valid, once that is free
// so each item passes the input register and then the result register around the datapath
// synchronous active-low reset clears both valid bits; payload registers are not reset
// a stall on the result side holds the result register, the input register keeps
// loading until it too is full, then o_ready drops
`include "assert_macros.svh"

module cpu8_alu_with_flags (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [c8alu_pkg::OP_W-1:0]          i_req_type,
    input  logic [c8alu_pkg::DATA_W-1:0]        i_operand,
    input  logic                                i_shift_accumulator,
    input  logic [c8alu_pkg::DATA_W-1:0]        i_acc_in,
    input  logic [c8alu_pkg::DATA_W-1:0]        i_index_x,
    input  logic [c8alu_pkg::DATA_W-1:0]        i_index_y,
    input  logic [c8alu_pkg::DATA_W-1:0]        i_status_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [c8alu_pkg::DATA_W-1:0]        o_acc_out,
    output logic [c8alu_pkg::DATA_W-1:0]        o_mem_out,
    output logic [c8alu_pkg::DATA_W-1:0]        o_status_out
);
    import c8alu_pkg::*;

    // input register
    logic r_in_valid;
    logic n_in_valid;
    t_req r_in;
    // result register
    logic r_out_valid;
    logic n_out_valid;
    t_res r_out;

    t_res core_res;
    logic out_load;
    logic in_load;

    // result register takes a new item when empty or being drained
    assign out_load = !r_out_valid || i_ready;
    // input register can load when empty or passing its item on
    assign o_ready  = !r_in_valid || out_load;
    assign in_load  = i_valid && o_ready;

    c8alu_core u_core (
        .i_req (r_in),
        .o_res (core_res)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (o_ready) begin
            n_in_valid = i_valid;
        end
        if (out_load) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in.req_type          <= i_req_type;
            r_in.operand           <= i_operand;
            r_in.shift_accumulator <= i_shift_accumulator;
            r_in.acc_in            <= i_acc_in;
            r_in.index_x           <= i_index_x;
            r_in.index_y           <= i_index_y;
            r_in.status_in         <= i_status_in;
        end
        if (out_load && r_in_valid) begin
            r_out <= core_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_acc_out    = r_out.acc_out;
    assign o_mem_out    = r_out.mem_out;
    assign o_status_out = r_out.status_out;

    // a staged item always reaches the result register on a free slot
    `ASSERT_CLK(a_stage_moves, i_clk, i_rst_n,
        (r_in_valid && out_load) |=> o_valid, "staged item lost")
    // status bits outside n, v, z and c pass untouched
    `ASSERT_CLK(a_status_keep, i_clk, i_rst_n,
        (r_in_valid && out_load) |=> (o_status_out[5:2] == $past(r_in.status_in[5:2])),
        "reserved status bits changed")
    // an accumulator shift leaves the memory byte alone
    `ASSERT_CLK(a_acc_shift_mem, i_clk, i_rst_n,
        (r_in_valid && out_load && r_in.shift_accumulator
            && (r_in.req_type >= OP_ASL) && (r_in.req_type <= OP_ROR))
            |=> (o_mem_out == $past(r_in.operand)),
        "memory byte changed by accumulator shift")
    // nothing is offered in the cycle after reset
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

// File: bench/cpu8_alu_with_flags_checker.sv
// result checker of the 8-bit alu: predicts each accepted item and compares the results
`timescale 1ns / 100ps

module cpu8_alu_with_flags_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  c8alu_pkg::t_req   i_req,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  c8alu_pkg::t_res   i_res,
    output int                o_pending,
    output int                o_fail_cnt
);
    import c8alu_pkg::*;

    localparam int REPORT_MAX = 10;

    t_res alu_expect_q[$];
    int   fail_total = 0;

    function automatic logic [7:0] with_nz(input logic [7:0] st, input logic [7:0] val);
        logic [7:0] upd;
        upd         = st;
        upd[FLAG_N] = val[7];
        upd[FLAG_Z] = (val == 8'h00);
        return upd;
    endfunction

    // binary-only alu behavior, decimal flag ignored
    function automatic t_res predict_alu(input t_req req);
        t_res       res;
        logic [7:0] st;
        logic [7:0] src;
        logic [7:0] shifted;
        logic [7:0] m_eff;
        logic [7:0] cmp_reg;
        logic [7:0] diff;
        logic [8:0] sum;
        logic       is_shift;
        res.acc_out    = req.acc_in;
        res.mem_out    = req.operand;
        st             = req.status_in;
        src            = req.shift_accumulator ? req.acc_in : req.operand;
        shifted        = 8'h00;
        is_shift       = 1'b0;
        cmp_reg        = req.acc_in;
        case (req.req_type)
            OP_ADC, OP_SBC: begin
                // subtract is add of the inverted operand with carry as not-borrow
                m_eff       = (req.req_type == OP_SBC) ? ~req.operand : req.operand;
                sum         = {1'b0, req.acc_in} + {1'b0, m_eff} + {8'h00, st[FLAG_C]};
                res.acc_out = sum[7:0];
                st          = with_nz(st, sum[7:0]);
                st[FLAG_C]  = sum[8];
                st[FLAG_V]  = (req.acc_in[7] == m_eff[7]) && (sum[7] != req.acc_in[7]);
            end
            OP_AND: begin
                res.acc_out = req.acc_in & req.operand;
                st          = with_nz(st, res.acc_out);
            end
            OP_ORA: begin
                res.acc_out = req.acc_in | req.operand;
                st          = with_nz(st, res.acc_out);
            end
            OP_EOR: begin
                res.acc_out = req.acc_in ^ req.operand;
                st          = with_nz(st, res.acc_out);
            end
            OP_BIT: begin
                st[FLAG_N] = req.operand[7];
                st[FLAG_V] = req.operand[6];
                st[FLAG_Z] = ((req.acc_in & req.operand) == 8'h00);
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                if (req.req_type == OP_CPX) begin
                    cmp_reg = req.index_x;
                end else if (req.req_type == OP_CPY) begin
                    cmp_reg = req.index_y;
                end
                diff       = cmp_reg - req.operand;
                st         = with_nz(st, diff);
                st[FLAG_C] = (cmp_reg >= req.operand);
            end
            OP_ASL: begin
                shifted  = {src[6:0], 1'b0};
                is_shift = 1'b1;
            end
            OP_LSR: begin
                shifted  = {1'b0, src[7:1]};
                is_shift = 1'b1;
            end
            OP_ROL: begin
                shifted  = {src[6:0], st[FLAG_C]};
                is_shift = 1'b1;
            end
            OP_ROR: begin
                shifted  = {st[FLAG_C], src[7:1]};
                is_shift = 1'b1;
            end
            default: begin
                // unused codes leave everything as it came in
            end
        endcase
        if (is_shift) begin
            st = with_nz(st, shifted);
            if (req.req_type == OP_ASL || req.req_type == OP_ROL) begin
                st[FLAG_C] = src[7];
            end else begin
                st[FLAG_C] = src[0];
            end
            if (req.shift_accumulator) begin
                res.acc_out = shifted;
            end else begin
                res.mem_out = shifted;
            end
        end
        res.status_out = st;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res exp_res;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                alu_expect_q.push_back(predict_alu(i_req));
            end
            if (i_res_valid && i_res_ready) begin
                if (alu_expect_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_MAX) begin
                        $display("unexpected result: acc %02h mem %02h status %02h",
                                 i_res.acc_out, i_res.mem_out, i_res.status_out);
                    end
                end else begin
                    exp_res = alu_expect_q.pop_front();
                    if (i_res.acc_out !== exp_res.acc_out ||
                        i_res.mem_out !== exp_res.mem_out ||
                        i_res.status_out !== exp_res.status_out) begin
                        fail_total++;
                        if (fail_total <= REPORT_MAX) begin
                            $display({"mismatch: acc exp %02h got %02h, ",
                                      "mem exp %02h got %02h, status exp %02h got %02h"},
                                     exp_res.acc_out, i_res.acc_out,
                                     exp_res.mem_out, i_res.mem_out,
                                     exp_res.status_out, i_res.status_out);
                        end
                    end
                end
            end
            o_pending  <= alu_expect_q.size();
            o_fail_cnt <= fail_total;
        end
    end

endmodule

// File: bench/tb_cpu8_alu_with_flags.sv
// testbench top of the 8-bit alu: clock, reset, stimulus, handshake pressure and verdict
`timescale 1ns / 100ps

module tb_cpu8_alu_with_flags;
    import c8alu_pkg::*;

    // codes the block treats as no operation
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd13;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;
    // decimal flag, ignored by the block
    localparam int unsigned FLAG_D = 3;

    localparam int RAND_PER_PHASE = 125;
    localparam int MAX_GAP        = 12;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int TAIL_CYCLES    = 8;
    // slowest run is about 525 items, each with a sender gap and a receiver gap of up to MAX_GAP
    // plus the pipeline latency, plus one long receiver hold; allow many times that
    localparam int CYCLE_LIMIT    = 200000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_acc_out;
    logic [7:0] o_mem_out;
    logic [7:0] o_status_out;
    t_req       req_drv;

    int   pending_cnt;
    int   fail_cnt;
    int   cycle_cnt = 0;

    // idling knobs per phase, and a one-shot request for a long receiver stall
    bit   tx_idle_on  = 1'b1;
    bit   rx_idle_on  = 1'b1;
    bit   rx_hold_req = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    cpu8_alu_with_flags dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_req_type          (req_drv.req_type),
        .i_operand           (req_drv.operand),
        .i_shift_accumulator (req_drv.shift_accumulator),
        .i_acc_in            (req_drv.acc_in),
        .i_index_x           (req_drv.index_x),
        .i_index_y           (req_drv.index_y),
        .i_status_in         (req_drv.status_in),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_acc_out           (o_acc_out),
        .o_mem_out           (o_mem_out),
        .o_status_out        (o_status_out)
    );

    cpu8_alu_with_flags_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_ready (o_ready),
        .i_req       (req_drv),
        .i_res_valid (o_valid),
        .i_res_ready (i_ready),
        .i_res       ({o_acc_out, o_mem_out, o_status_out}),
        .o_pending   (pending_cnt),
        .o_fail_cnt  (fail_cnt)
    );

    // run-away guard
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_req make_req(input logic [OP_W-1:0] op, input logic [7:0] m,
                                      input logic sa, input logic [7:0] a,
                                      input logic [7:0] x, input logic [7:0] y,
                                      input logic [7:0] st);
        t_req r;
        r.req_type          = op;
        r.operand           = m;
        r.shift_accumulator = sa;
        r.acc_in            = a;
        r.index_x           = x;
        r.index_y           = y;
        r.status_in         = st;
        return r;
    endfunction

    // byte biased toward the corners where flags flip
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h7f;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_req rand_item();
        t_req r;
        // mostly real operations, a few no-op codes as noise
        if ($urandom_range(9) == 0) begin
            r.req_type = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        end else begin
            r.req_type = 4'($urandom_range(OP_ROR, OP_ADC));
        end
        r.operand           = pick_byte();
        r.shift_accumulator = 1'($urandom);
        r.acc_in            = pick_byte();
        r.index_x           = pick_byte();
        r.index_y           = pick_byte();
        r.status_in         = 8'($urandom);
        // equal compares now and then, so zero and carry both come up
        if ($urandom_range(5) == 0) begin
            case (r.req_type)
                OP_CPX:  r.operand = r.index_x;
                OP_CPY:  r.operand = r.index_y;
                default: r.operand = r.acc_in;
            endcase
        end
        return r;
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_item(input t_req r);
        int gap;
        gap = tx_idle_on ? $urandom_range(MAX_GAP) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        req_drv <= r;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // sender pause until every outstanding result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    // result side: random stall per item, plus the long hold when asked
    initial begin : result_sink
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            gap = rx_idle_on ? $urandom_range(MAX_GAP) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid && !rx_hold_req);
        end
    end

    initial begin : stimulus
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        req_drv <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: arithmetic corners
        send_item(make_req(OP_ADC, 8'h01, 1'b0, 8'h7f, 8'h00, 8'h00, 8'h00)); // signed overflow
        send_item(make_req(OP_ADC, 8'h00, 1'b0, 8'hff, 8'hff, 8'hff, 8'h01)); // carry in wraps
        send_item(make_req(OP_ADC, 8'h80, 1'b1, 8'h80, 8'h55, 8'haa, 8'h00)); // carry and ovf
        send_item(make_req(OP_SBC, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 8'h01)); // borrow
        send_item(make_req(OP_SBC, 8'h01, 1'b0, 8'h80, 8'h00, 8'h00, 8'h01)); // sub overflow
        send_item(make_req(OP_SBC, 8'h50, 1'b0, 8'h50, 8'h00, 8'h00, 8'hfe)); // clear carry
        send_item(make_req(OP_ADC, 8'h0f, 1'b0, 8'h19, 8'h00, 8'h00,
                           8'h01 | (8'h01 << FLAG_D)));                       // decimal flag ignored
        // logic ops and bit test
        send_item(make_req(OP_AND, 8'h00, 1'b0, 8'hff, 8'h00, 8'h00, 8'hff));
        send_item(make_req(OP_ORA, 8'h00, 1'b0, 8'h80, 8'h00, 8'h00, 8'h00));
        send_item(make_req(OP_EOR, 8'hff, 1'b0, 8'hff, 8'h00, 8'h00, 8'h80));
        send_item(make_req(OP_BIT, 8'hc0, 1'b0, 8'h3f, 8'h00, 8'h00, 8'h00));
        // compares: equal, register below, register above
        send_item(make_req(OP_CMP, 8'h40, 1'b0, 8'h40, 8'h00, 8'h00, 8'h00));
        send_item(make_req(OP_CPX, 8'hff, 1'b0, 8'h00, 8'h00, 8'hff, 8'hff));
        send_item(make_req(OP_CPY, 8'h00, 1'b0, 8'h00, 8'h00, 8'hff, 8'h00));
        // shifts on memory and on the accumulator, carry in both ways
        send_item(make_req(OP_ASL, 8'h80, 1'b0, 8'h12, 8'h00, 8'h00, 8'h00));
        send_item(make_req(OP_ASL, 8'h34, 1'b1, 8'hff, 8'h00, 8'h00, 8'h00));
        send_item(make_req(OP_LSR, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 8'h80)); // n cleared
        send_item(make_req(OP_LSR, 8'h00, 1'b1, 8'hff, 8'h00, 8'h00, 8'hff));
        send_item(make_req(OP_ROL, 8'h80, 1'b0, 8'h00, 8'h00, 8'h00, 8'h01));
        send_item(make_req(OP_ROL, 8'hff, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(make_req(OP_ROR, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 8'h01));
        send_item(make_req(OP_ROR, 8'h00, 1'b1, 8'hfe, 8'h00, 8'h00, 8'h00));
        // unused codes pass everything through
        send_item(make_req(OP_UNUSED_LO, 8'h5a, 1'b1, 8'ha5, 8'h3c, 8'hc3, 8'h00));
        send_item(make_req(OP_UNUSED_HI, 8'hff, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff));
        wait_drained();

        // random, both sides idling
        repeat (RAND_PER_PHASE) send_item(rand_item());
        wait_drained();

        // random, no idling at all
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (RAND_PER_PHASE) send_item(rand_item());
        wait_drained();

        // back-to-back sender while the receiver stalls for a long stretch,
        // so the pipeline fills and o_ready drops
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b1;
        repeat (RAND_PER_PHASE) send_item(rand_item());
        wait_drained();

        // random sender gaps, receiver always ready
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        repeat (RAND_PER_PHASE) send_item(rand_item());
        wait_drained();

        // let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
